// ----- rtl/pal_pkg.sv -----
// Shared types, constants and helper functions for the PIN attempt lockout block.
// Depends on nothing; every other file of the block imports it.
package pal_pkg;

  // Field widths.
  localparam int CNT_W  = 4;
  localparam int SEC_W  = 16;
  localparam int US_W   = 36;
  localparam int TIME_W = 63;
  localparam int FN_W   = 2;
  localparam int ST_W   = 3;
  localparam int DIG_W  = 4;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam int PIN_DIGITS = 4;
  localparam int PIN_W      = PIN_DIGITS * DIG_W;
  localparam int WEAK_COUNT = 36;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [19:0]      US_PER_SEC = 20'd1000000;

  // Exact reciprocal of 15625 for dividends below 2**30 (1000000 = 64 * 15625).
  localparam int          QX_W        = 30;
  localparam int          RECIP_W     = 31;
  localparam int          RECIP_SHIFT = 44;
  localparam int          PROD_W      = QX_W + RECIP_W;
  localparam logic [30:0] RECIP_M     = 31'd1125899907;

  // Function codes of a request.
  localparam logic [FN_W-1:0] FN_VERIFY   = 2'd0;
  localparam logic [FN_W-1:0] FN_REGISTER = 2'd1;
  localparam logic [FN_W-1:0] FN_QUERY    = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_WRONG    = 3'd1;
  localparam logic [ST_W-1:0] ST_COOLDOWN = 3'd2;
  localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd3;
  localparam logic [ST_W-1:0] ST_WEAK     = 3'd4;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_SHORT_THR = 3'd0;
  localparam logic [IDX_W-1:0] REG_SHORT_SEC = 3'd1;
  localparam logic [IDX_W-1:0] REG_LONG_THR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LONG_SEC  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLOCK_THR = 3'd4;

  // Reset values of the registers.
  localparam logic [CNT_W-1:0] RST_SHORT_THR = 4'd3;
  localparam logic [SEC_W-1:0] RST_SHORT_SEC = 16'd30;
  localparam logic [US_W-1:0]  RST_SHORT_US  = 36'd30000000;
  localparam logic [CNT_W-1:0] RST_LONG_THR  = 4'd5;
  localparam logic [SEC_W-1:0] RST_LONG_SEC  = 16'd300;
  localparam logic [US_W-1:0]  RST_LONG_US   = 36'd300000000;
  localparam logic [CNT_W-1:0] RST_BLOCK_THR = 4'd10;

  // Weak PINs, first digit in the top nibble.
  localparam logic [PIN_W-1:0] WEAK_PINS [WEAK_COUNT] = '{
    16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
    16'h5555, 16'h6666, 16'h7777, 16'h8888, 16'h9999,
    16'h0123, 16'h1234, 16'h2345, 16'h3456, 16'h4567,
    16'h5678, 16'h6789,
    16'h9876, 16'h8765, 16'h7654, 16'h6543, 16'h5432, 16'h4321,
    16'h3210,
    16'h2024, 16'h2025, 16'h2026, 16'h2000, 16'h1999,
    16'h1357, 16'h2468, 16'h0852,
    16'h0001, 16'h1000, 16'h1212, 16'h0011
  };

  // Register contents; the delays are also kept in microseconds.
  typedef struct packed {
    logic [CNT_W-1:0] short_thr;
    logic [SEC_W-1:0] short_sec;
    logic [US_W-1:0]  short_us;
    logic [CNT_W-1:0] long_thr;
    logic [SEC_W-1:0] long_sec;
    logic [US_W-1:0]  long_us;
    logic [CNT_W-1:0] block_thr;
  } cfg_t;

  // Delay that applies to one failure count.
  typedef struct packed {
    logic             blocked;
    logic [SEC_W-1:0] sec;
    logic [US_W-1:0]  us;
  } dly_t;

  function automatic dly_t delay_for(logic [CNT_W-1:0] count, cfg_t cfg);
    dly_t d;
    d = '0;
    if (count >= cfg.block_thr) begin
      d.blocked = 1'b1;
    end else if (count >= cfg.long_thr) begin
      d.sec = cfg.long_sec;
      d.us  = cfg.long_us;
    end else if (count >= cfg.short_thr) begin
      d.sec = cfg.short_sec;
      d.us  = cfg.short_us;
    end
    return d;
  endfunction

  // True when the digits equal one entry of the weak list.
  function automatic logic is_weak(logic [PIN_W-1:0] pin);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < WEAK_COUNT; i++) begin
      if (pin == WEAK_PINS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- rtl/pal_in_if.sv -----
// Request channel of the PIN attempt lockout block: valid, ready and the request fields.
// Depends on pal_pkg for the field widths.
interface pal_in_if import pal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FN_W-1:0]   func;
  logic [DIG_W-1:0]  digit_0;
  logic [DIG_W-1:0]  digit_1;
  logic [DIG_W-1:0]  digit_2;
  logic [DIG_W-1:0]  digit_3;
  logic              pin_matches;
  logic [TIME_W-1:0] now_us;

  modport source (
    output valid, func, digit_0, digit_1, digit_2, digit_3, pin_matches, now_us,
    input  ready
  );
  modport sink (
    input  valid, func, digit_0, digit_1, digit_2, digit_3, pin_matches, now_us,
    output ready
  );
endinterface

// ----- rtl/pal_out_if.sv -----
// Result channel of the PIN attempt lockout block: valid, ready, status and seconds left.
// Depends on pal_pkg for the field widths.
interface pal_out_if import pal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [SEC_W-1:0] remaining_seconds;

  modport source (output valid, status, remaining_seconds, input ready);
  modport sink (input valid, status, remaining_seconds, output ready);
endinterface

// ----- rtl/pal_cfg_regs.sv -----
// APB-style register file of the PIN attempt lockout block.
// Depends on pal_pkg; also keeps each delay converted to microseconds.
module pal_cfg_regs import pal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t             cfg_r;
  logic             wr_en;
  logic [IDX_W-1:0] idx;
  logic [US_W-1:0]  wr_us;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  // Seconds to microseconds for the delay being written.
  assign wr_us = US_W'(pwdata[SEC_W-1:0]) * US_W'(US_PER_SEC);

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_thr <= RST_SHORT_THR;
      cfg_r.short_sec <= RST_SHORT_SEC;
      cfg_r.short_us  <= RST_SHORT_US;
      cfg_r.long_thr  <= RST_LONG_THR;
      cfg_r.long_sec  <= RST_LONG_SEC;
      cfg_r.long_us   <= RST_LONG_US;
      cfg_r.block_thr <= RST_BLOCK_THR;
    end else if (wr_en) begin
      unique case (idx)
        REG_SHORT_THR: cfg_r.short_thr <= pwdata[CNT_W-1:0];
        REG_SHORT_SEC: begin
          cfg_r.short_sec <= pwdata[SEC_W-1:0];
          cfg_r.short_us  <= wr_us;
        end
        REG_LONG_THR: cfg_r.long_thr <= pwdata[CNT_W-1:0];
        REG_LONG_SEC: begin
          cfg_r.long_sec <= pwdata[SEC_W-1:0];
          cfg_r.long_us  <= wr_us;
        end
        REG_BLOCK_THR: cfg_r.block_thr <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_SHORT_THR: prdata = DATA_W'(cfg_r.short_thr);
      REG_SHORT_SEC: prdata = DATA_W'(cfg_r.short_sec);
      REG_LONG_THR:  prdata = DATA_W'(cfg_r.long_thr);
      REG_LONG_SEC:  prdata = DATA_W'(cfg_r.long_sec);
      REG_BLOCK_THR: prdata = DATA_W'(cfg_r.block_thr);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/pin_attempt_lockout.sv -----
// PIN attempt guard with escalating lockout; uses pal_pkg, the channel interfaces and pal_cfg_regs.
// A request passes the input register, the decision register, the reciprocal multiply register
// and the result register in that order.
// Throughput: one request per cycle; a stage holds only while it and every later stage are full
// behind a held result.
// Reset (synchronous, rst_n low): failure count and last failure time clear to zero,
// registers take their defaults, and all stages empty.
module pin_attempt_lockout import pal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pal_in_if.sink            in_ch,
  pal_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  pal_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic adv0, adv1, adv2, adv3;
  logic v0_r, v1_r, v2_r, out_v_r;

  assign adv3 = !out_v_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign in_ch.ready = adv0;

  // Input register.
  logic [FN_W-1:0]   func0_r;
  logic [PIN_W-1:0]  pin0_r;
  logic              match0_r;
  logic [TIME_W-1:0] now0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv0) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_ch.valid) begin
      func0_r  <= in_ch.func;
      pin0_r   <= {in_ch.digit_0, in_ch.digit_1, in_ch.digit_2, in_ch.digit_3};
      match0_r <= in_ch.pin_matches;
      now0_r   <= in_ch.now_us;
    end
  end

  // Guard state.
  logic [CNT_W-1:0]  fail_cnt_r, fail_cnt_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  // Decision logic on the request in the input register.
  dly_t              cur_dly, new_dly;
  logic [CNT_W-1:0]  inc_cnt;
  logic              has_dly, back, cool, weak_hit;
  logic [TIME_W-1:0] diff;
  logic [ST_W-1:0]   st1_nxt;
  logic              calc1_nxt;
  logic [SEC_W-1:0]  base1_nxt;

  assign cur_dly = delay_for(fail_cnt_r, cfg);
  assign inc_cnt = (fail_cnt_r == COUNT_MAX) ? COUNT_MAX : fail_cnt_r + 1'b1;
  assign new_dly = delay_for(inc_cnt, cfg);
  assign has_dly = !cur_dly.blocked && (cur_dly.sec != '0);
  assign back    = now0_r < last_r;
  assign diff    = now0_r - last_r;
  // Still cooling down: fewer whole seconds gone by than the delay.
  assign cool    = has_dly && !back && (diff[TIME_W-1:US_W] == '0)
                   && (diff[US_W-1:0] < cur_dly.us);
  assign weak_hit = is_weak(pin0_r);

  always_comb begin
    st1_nxt      = ST_OK;
    calc1_nxt    = 1'b0;
    base1_nxt    = '0;
    fail_cnt_nxt = fail_cnt_r;
    last_nxt     = last_r;
    unique case (func0_r)
      FN_VERIFY: begin
        if (cur_dly.blocked) begin
          st1_nxt = ST_BLOCKED;
        end else if (has_dly && back) begin
          // The clock went backwards: restart the cooldown from now.
          last_nxt  = now0_r;
          st1_nxt   = ST_COOLDOWN;
          base1_nxt = cur_dly.sec;
        end else if (cool) begin
          st1_nxt   = ST_COOLDOWN;
          calc1_nxt = 1'b1;
          base1_nxt = cur_dly.sec;
        end else if (match0_r) begin
          fail_cnt_nxt = '0;
        end else begin
          fail_cnt_nxt = inc_cnt;
          last_nxt     = now0_r;
          st1_nxt      = new_dly.blocked ? ST_BLOCKED : ST_WRONG;
          base1_nxt    = new_dly.sec;
        end
      end
      FN_REGISTER: begin
        if (weak_hit) begin
          st1_nxt = ST_WEAK;
          if (has_dly && back) begin
            base1_nxt = cur_dly.sec;
          end else if (cool) begin
            calc1_nxt = 1'b1;
            base1_nxt = cur_dly.sec;
          end
        end else begin
          fail_cnt_nxt = '0;
        end
      end
      default: begin
        // Query, and the unused code handled the same way.
        if (cur_dly.blocked) begin
          st1_nxt = ST_BLOCKED;
        end else if (has_dly && back) begin
          st1_nxt   = ST_COOLDOWN;
          base1_nxt = cur_dly.sec;
        end else if (cool) begin
          st1_nxt   = ST_COOLDOWN;
          calc1_nxt = 1'b1;
          base1_nxt = cur_dly.sec;
        end
      end
    endcase
  end

  // State updates once per request, as it leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r <= '0;
      last_r     <= '0;
    end else if (v0_r && adv1) begin
      fail_cnt_r <= fail_cnt_nxt;
      last_r     <= last_nxt;
    end
  end

  // Decision register; keeps the elapsed time divided by 64 for the divider.
  logic [ST_W-1:0]  st1_r;
  logic             calc1_r;
  logic [SEC_W-1:0] base1_r;
  logic [QX_W-1:0]  x1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && v0_r) begin
      st1_r   <= st1_nxt;
      calc1_r <= calc1_nxt;
      base1_r <= base1_nxt;
      x1_r    <= diff[US_W-1:US_W-QX_W];
    end
  end

  // Whole elapsed seconds: multiply by the reciprocal of 15625 and keep the high bits.
  logic [PROD_W-1:0] prod;
  logic [ST_W-1:0]   st2_r;
  logic              calc2_r;
  logic [SEC_W-1:0]  base2_r;
  logic [SEC_W-1:0]  q2_r;

  assign prod = PROD_W'(x1_r) * PROD_W'(RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      st2_r   <= st1_r;
      calc2_r <= calc1_r;
      base2_r <= base1_r;
      q2_r    <= prod[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
    end
  end

  // Result register: remaining seconds are the delay minus elapsed seconds while cooling down, else the decided value.
  logic [ST_W-1:0]  out_st_r;
  logic [SEC_W-1:0] out_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv3) begin
      out_v_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      out_st_r  <= st2_r;
      out_rem_r <= calc2_r ? base2_r - q2_r : base2_r;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.status            = out_st_r;
  assign out_ch.remaining_seconds = out_rem_r;

endmodule

// ----- tb/sv/tb_pin_attempt_lockout.sv -----
// Self-checking testbench for pin_attempt_lockout: directed and random verify, register and
// query requests under several lockout settings, checked against a cycle-free predictor.
// Depends on pal_pkg, pal_in_if, pal_out_if and the pin_attempt_lockout RTL.
module tb_pin_attempt_lockout import pal_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY       = 3;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 270;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [63:0]     US_PER_S  = 64'd1000000;
  localparam logic [IDX_W-1:0] REG_ORDER [5] = '{
    REG_SHORT_THR, REG_SHORT_SEC, REG_LONG_THR, REG_LONG_SEC, REG_BLOCK_THR
  };

  typedef struct {
    logic [FN_W-1:0]   func;
    logic [PIN_W-1:0]  pin;
    logic              pin_matches;
    logic [TIME_W-1:0] now_us;
  } pal_request_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [SEC_W-1:0] secs;
  } attempt_verdict_t;

  typedef struct packed {
    logic             blocked;
    logic [SEC_W-1:0] secs;
  } lock_hold_t;

  typedef enum {DRAIN_FREE, DRAIN_TOGGLE, DRAIN_RANDOM, DRAIN_SLOW} drain_mode_t;

  // Tracks the guard's count, last failure time and settings, and predicts each verdict.
  class lockout_scoreboard;
    logic [CNT_W-1:0] short_thr, long_thr, block_thr;
    logic [SEC_W-1:0] short_sec, long_sec;
    logic [CNT_W-1:0] failures;
    logic [63:0]      last_miss_us;
    attempt_verdict_t pending_verdicts[$];
    int unsigned      mismatches;

    function new();
      short_thr    = RST_SHORT_THR;
      short_sec    = RST_SHORT_SEC;
      long_thr     = RST_LONG_THR;
      long_sec     = RST_LONG_SEC;
      block_thr    = RST_BLOCK_THR;
      failures     = '0;
      last_miss_us = '0;
      mismatches   = 0;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_SHORT_THR: short_thr = value[CNT_W-1:0];
        REG_SHORT_SEC: short_sec = value[SEC_W-1:0];
        REG_LONG_THR:  long_thr  = value[CNT_W-1:0];
        REG_LONG_SEC:  long_sec  = value[SEC_W-1:0];
        REG_BLOCK_THR: block_thr = value[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [IDX_W-1:0] idx);
      case (idx)
        REG_SHORT_THR: return 32'(short_thr);
        REG_SHORT_SEC: return 32'(short_sec);
        REG_LONG_THR:  return 32'(long_thr);
        REG_LONG_SEC:  return 32'(long_sec);
        REG_BLOCK_THR: return 32'(block_thr);
        default:       return '0;
      endcase
    endfunction

    // Block or cooldown length that a given failure count calls for.
    function lock_hold_t hold_for(logic [CNT_W-1:0] count);
      lock_hold_t h;
      h = '0;
      if (count >= block_thr) h.blocked = 1'b1;
      else if (count >= long_thr) h.secs = long_sec;
      else if (count >= short_thr) h.secs = short_sec;
      return h;
    endfunction

    // Whole seconds of a cooldown still to run at a given time.
    function logic [SEC_W-1:0] seconds_left(logic [SEC_W-1:0] secs, logic [63:0] now);
      logic [63:0] elapsed;
      if (now < last_miss_us) return secs;
      elapsed = (now - last_miss_us) / US_PER_S;
      if (elapsed >= 64'(secs)) return '0;
      return secs - elapsed[SEC_W-1:0];
    endfunction

    function logic weak_pin(logic [PIN_W-1:0] pin);
      foreach (WEAK_PINS[i]) if (WEAK_PINS[i] == pin) return 1'b1;
      return 1'b0;
    endfunction

    // Applies one accepted request to the predicted state and queues its verdict.
    function void note_request(pal_request_t r);
      lock_hold_t       h;
      attempt_verdict_t v;
      logic [63:0]      now;
      now = {1'b0, r.now_us};
      h = hold_for(failures);
      v.status = ST_OK;
      v.secs = '0;
      case (r.func)
        FN_VERIFY: begin
          if (h.blocked) begin
            v.status = ST_BLOCKED;
          end else if (h.secs != 0 && now < last_miss_us) begin
            // Clock went backwards: restart the cooldown from now.
            last_miss_us = now;
            v.status = ST_COOLDOWN;
            v.secs = h.secs;
          end else if (h.secs != 0 && seconds_left(h.secs, now) != 0) begin
            v.status = ST_COOLDOWN;
            v.secs = seconds_left(h.secs, now);
          end else if (r.pin_matches) begin
            failures = '0;
          end else begin
            if (failures != COUNT_MAX) failures = failures + 1'b1;
            last_miss_us = now;
            h = hold_for(failures);
            if (h.blocked) begin
              v.status = ST_BLOCKED;
            end else begin
              v.status = ST_WRONG;
              v.secs = h.secs;
            end
          end
        end
        FN_REGISTER: begin
          if (weak_pin(r.pin)) begin
            v.status = ST_WEAK;
            if (!h.blocked && h.secs != 0) v.secs = seconds_left(h.secs, now);
          end else begin
            failures = '0;
          end
        end
        default: begin
          // Query, and the unused code that behaves as one.
          if (h.blocked) begin
            v.status = ST_BLOCKED;
          end else if (h.secs != 0) begin
            v.secs = seconds_left(h.secs, now);
            if (v.secs != 0) v.status = ST_COOLDOWN;
          end
        end
      endcase
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic [ST_W-1:0] status, logic [SEC_W-1:0] secs);
      attempt_verdict_t v;
      if (pending_verdicts.size() == 0) begin
        flag("unexpected result status", 0, 32'(status));
        return;
      end
      v = pending_verdicts.pop_front();
      if (status !== v.status) flag("status", 32'(v.status), 32'(status));
      if (secs !== v.secs) flag("remaining_seconds", 32'(v.secs), 32'(secs));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  pal_in_if  in_ch ();
  pal_out_if out_ch ();

  pin_attempt_lockout uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lockout_scoreboard sb;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  logic [62:0] t_now = '0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one request in bursts with random gaps; returns at the falling edge after acceptance.
  task automatic send_request(input pal_request_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.func        = r.func;
    in_ch.digit_0     = r.pin[15:12];
    in_ch.digit_1     = r.pin[11:8];
    in_ch.digit_2     = r.pin[7:4];
    in_ch.digit_3     = r.pin[3:0];
    in_ch.pin_matches = r.pin_matches;
    in_ch.now_us      = r.now_us;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  function automatic pal_request_t req(logic [FN_W-1:0] func, logic [PIN_W-1:0] pin,
                                       logic pin_ok, logic [TIME_W-1:0] now);
    pal_request_t r;
    r.func = func;
    r.pin = pin;
    r.pin_matches = pin_ok;
    r.now_us = now;
    return r;
  endfunction

  // Holds the sender off until every verdict is back and the pipeline has emptied.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic [IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_W'(idx) << 2;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_back(input logic [IDX_W-1:0] idx);
    logic [31:0] got;
    logic [31:0] mask;
    apb_access(1'b0, idx, '0, got);
    mask = (idx == REG_SHORT_SEC || idx == REG_LONG_SEC) ? 32'hFFFF : 32'hF;
    if ((got & mask) !== sb.register_value(idx)) sb.flag("register readback",
                                                         sb.register_value(idx), got);
  endtask

  // Loads the lockout settings of one phase, fixed settings first, random ones last.
  task automatic program_phase(input int ph);
    logic [31:0] vals [5];
    logic [31:0] unused;
    case (ph)
      1:       vals = '{32'd1, 32'd0, 32'd2, 32'd1, 32'd4};
      2:       vals = '{32'd1, 32'd65535, 32'd2, 32'd0, 32'd15};
      3:       vals = '{32'd2, 32'd3, 32'd4, 32'd7, 32'd6};
      4:       vals = '{32'd15, 32'd1, 32'd15, 32'd65535, 32'd15};
      5:       vals = '{32'd6, 32'd4, 32'd3, 32'd9, 32'd1};
      default: vals = '{$urandom_range(1, 15), $urandom_range(0, 65535),
                        $urandom_range(1, 15), $urandom_range(0, 65535),
                        $urandom_range(1, 15)};
    endcase
    foreach (REG_ORDER[i]) begin
      apb_access(1'b1, REG_ORDER[i], vals[i], unused);
      sb.set_register(REG_ORDER[i], vals[i]);
      read_back(REG_ORDER[i]);
    end
  endtask

  // Random request whose time often lands near the current cooldown boundary.
  task automatic make_random_request(output pal_request_t r);
    lock_hold_t  h;
    logic [63:0] target;
    logic [63:0] wide;
    int          pick;
    h = sb.hold_for(sb.failures);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      t_now = t_now + 63'($urandom_range(0, 2000000));
    end else if (pick < 65 && !h.blocked && h.secs != 0) begin
      target = sb.last_miss_us + 64'(h.secs) * US_PER_S;
      case ($urandom_range(0, 3))
        0:       target = target - 64'd1;
        1:       ;
        2:       target = target - 64'($urandom_range(0, 999999));
        default: target = target + 64'($urandom_range(0, 2000000));
      endcase
      t_now = target[62:0];
    end else if (pick < 80) begin
      t_now = t_now + 63'($urandom_range(0, 120)) * 63'd1000000
            + 63'($urandom_range(0, 999999));
    end else if (pick < 88) begin
      // Clock jumps backwards.
      if (sb.last_miss_us > 64'd5000000)
        t_now = sb.last_miss_us[62:0] - 63'($urandom_range(1, 5000000));
      else
        t_now = 63'($urandom_range(0, 999));
    end else begin
      t_now = t_now + 63'($urandom_range(0, 50));
    end
    wide = {$urandom, $urandom};
    r.now_us = ($urandom_range(0, 19) == 0) ? wide[62:0] : t_now;
    r.pin = 16'($urandom);
    r.pin_matches = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      r.func = FN_VERIFY;
      r.pin_matches = ($urandom_range(0, 4) == 0);
    end else if (pick < 72) begin
      r.func = FN_REGISTER;
      if ($urandom_range(0, 4) < 3) r.pin = WEAK_PINS[$urandom_range(0, WEAK_COUNT - 1)];
    end else if (pick < 95) begin
      r.func = FN_QUERY;
    end else begin
      r.func = FN_UNUSED;
    end
  endtask

  // Result side: stalls on a pattern that switches to a random mode after a random run.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (drain_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 3));
        drain_left = $urandom_range(8, 64);
      end
      drain_left--;
      case (drain_mode)
        DRAIN_FREE:   out_ch.ready = 1'b1;
        DRAIN_TOGGLE: out_ch.ready = !out_ch.ready;
        DRAIN_RANDOM: out_ch.ready = ($urandom_range(0, 9) >= 3);
        default:      out_ch.ready = (drain_left % 8 == 0);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.remaining_seconds);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence: reset, directed requests, then random phases under changing settings.
  initial begin
    pal_request_t r;
    logic [62:0]  t;
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_VERIFY;
    in_ch.digit_0 = '0;
    in_ch.digit_1 = '0;
    in_ch.digit_2 = '0;
    in_ch.digit_3 = '0;
    in_ch.pin_matches = 1'b0;
    in_ch.now_us = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (REG_ORDER[i]) read_back(REG_ORDER[i]);

    // Free state: query, a correct PIN, weak and non-weak registrations.
    send_request(req(FN_QUERY, 16'h0000, 1'b0, '0));
    send_request(req(FN_VERIFY, 16'h9999, 1'b1, '0));
    send_request(req(FN_REGISTER, 16'h0852, 1'b0, '0));
    send_request(req(FN_REGISTER, 16'h1234, 1'b1, 63'd5));
    send_request(req(FN_REGISTER, 16'hFFFF, 1'b0, 63'd7));
    // Three wrong PINs reach the short delay.
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, 63'd1000000));
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, 63'd2000000));
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, 63'd3000000));
    // One microsecond short of the cooldown end.
    t = 63'd3000000 + 63'd29999999;
    send_request(req(FN_VERIFY, 16'h4821, 1'b1, t));
    send_request(req(FN_QUERY, 16'h0000, 1'b0, t));
    send_request(req(FN_REGISTER, 16'h1111, 1'b0, t));
    // Backwards clock restarts the cooldown, then the unused code acts as a query.
    send_request(req(FN_VERIFY, 16'h4821, 1'b1, 63'd1000));
    t = 63'd1000 + 63'd30000000;
    send_request(req(FN_UNUSED, 16'h0000, 1'b0, t));
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, t));
    t = t + 63'd30000000;
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, t));
    // Long delays up to the permanent block.
    repeat (5) begin
      t = t + 63'd300000000;
      send_request(req(FN_VERIFY, 16'h4821, 1'b0, t));
    end
    send_request(req(FN_VERIFY, 16'h4821, 1'b1, t));
    send_request(req(FN_QUERY, 16'h0000, 1'b0, t));
    send_request(req(FN_REGISTER, 16'h2468, 1'b0, t));
    send_request(req(FN_REGISTER, 16'h5009, 1'b0, t));
    // Largest time value.
    send_request(req(FN_VERIFY, 16'h4821, 1'b1, '1));
    send_request(req(FN_VERIFY, 16'h4821, 1'b0, '1));

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        program_phase(ph);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_idle();
        make_random_request(r);
        send_request(r);
      end
    end

    wait_idle();
    repeat (LATENCY + 5) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
